// ----- sv/dqrv_pkg.sv -----
// Shared types and constants for the deque with remove-by-value.
// Used by deque_with_remove_by_value.sv and its test bench; depends on nothing.

package dqrv_pkg;

	// Port field widths fixed by the stream format
	localparam int unsigned OPCODE_W    = 3;
	localparam int unsigned DATA_WORD_W = 32;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned COUNT_OUT_W = 5;
	localparam int unsigned M_TDATA_W   = 8;
	localparam int unsigned MAX_WORD_W  = 64;

	// Parameter defaults for the top level
	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned WORD_WIDTH_DEF = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH     = 3'd0,
		OP_POP_OLD  = 3'd1,
		OP_POP_NEW  = 3'd2,
		OP_REMOVE   = 3'd3,
		OP_CLEAR    = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DONE
	} state_t;

endpackage

// ----- sv/deque_with_remove_by_value.sv -----
// Top level of the deque with remove-by-value: sequencer, pointers and output register.
// Depends on dqrv_pkg.sv and dqrv_ram.sv.
//
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  s_tuser = opcode, s_tdata = data_word
// m_*      out        m_tvalid/m_tready  m_tdata = status, entry_count
//
// Push, pop and clear pass from request through decode to the done state. Remove
// scans entries, a read state and a compare state per entry, through the single
// RAM read port and one shared comparator, then closes the gap with a read state
// and a write state per moved entry. s_tready is high only while the sequencer is idle.
// Reset clears the count, the oldest pointer and the sequencer; the RAM keeps
// stale data. A stalled result waits in the output register and holds the
// sequencer before its next result only.

module deque_with_remove_by_value #(
	parameter int unsigned DEPTH      = dqrv_pkg::DEPTH_DEF,
	parameter int unsigned WORD_WIDTH = dqrv_pkg::WORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [dqrv_pkg::OPCODE_W-1:0]    s_tuser,   // [2:0] opcode
	input  logic [dqrv_pkg::DATA_WORD_W-1:0] s_tdata,   // [31:0] data_word
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dqrv_pkg::M_TDATA_W-1:0]   m_tdata    // [1:0] status, [6:2] entry_count
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dqrv_pkg::state_t  state_q, state_d;
	dqrv_pkg::opcode_t op_q;
	dqrv_pkg::status_t status_q;
	dqrv_pkg::status_t out_status_q;

	logic [WORD_WIDTH-1:0]             key_q;
	logic [dqrv_pkg::MAX_WORD_W-1:0]   word_ext;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     idx_q;
	logic [CW-1:0]                     idx_inc;
	logic [AW-1:0]                     oldest_q;
	logic [dqrv_pkg::COUNT_OUT_W-1:0]  out_count_q;
	logic                              out_valid_q;

	logic [CW-1:0]     slot_k;
	logic [AW:0]       slot_sum;
	logic [AW-1:0]     slot;
	logic              out_free;
	logic              accept;
	logic              ram_we;
	logic [WORD_WIDTH-1:0] ram_rdata;
	logic              hit;
	logic              is_full;
	logic              is_empty;

	assign word_ext = dqrv_pkg::MAX_WORD_W'(s_tdata);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign idx_inc  = idx_q + CW'(1);
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign hit      = (ram_rdata == key_q);

	// Select the logical position for the shared slot adder
	always_comb begin
		case (state_q)
			dqrv_pkg::ST_DECODE: begin
				slot_k = (op_q == dqrv_pkg::OP_POP_OLD) ? CW'(1) : count_q;
			end
			dqrv_pkg::ST_SHIFT_RD: slot_k = idx_inc;
			default:               slot_k = idx_q;
		endcase
	end

	// Wrap oldest + k into the circular buffer: one compare and subtract
	assign slot_sum = (AW+1)'(oldest_q) + (AW+1)'(slot_k);
	assign slot     = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
	                                               : AW'(slot_sum);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dqrv_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = dqrv_pkg::ST_DECODE;
			end
			dqrv_pkg::ST_DECODE: begin
				if (op_q == dqrv_pkg::OP_REMOVE && !is_empty) state_d = dqrv_pkg::ST_SCAN_RD;
				else state_d = dqrv_pkg::ST_DONE;
			end
			dqrv_pkg::ST_SCAN_RD: state_d = dqrv_pkg::ST_SCAN_CMP;
			dqrv_pkg::ST_SCAN_CMP: begin
				if (hit) state_d = dqrv_pkg::ST_SHIFT_RD;
				else if (idx_inc == count_q) state_d = dqrv_pkg::ST_DONE;
				else state_d = dqrv_pkg::ST_SCAN_RD;
			end
			dqrv_pkg::ST_SHIFT_RD: begin
				if (idx_inc < count_q) state_d = dqrv_pkg::ST_SHIFT_WR;
				else state_d = dqrv_pkg::ST_DONE;
			end
			dqrv_pkg::ST_SHIFT_WR: state_d = dqrv_pkg::ST_SHIFT_RD;
			dqrv_pkg::ST_DONE: begin
				if (out_free) state_d = dqrv_pkg::ST_IDLE;
			end
			default: state_d = dqrv_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		ram_we   = 1'b0;
		case (state_q)
			dqrv_pkg::ST_IDLE:     s_tready = 1'b1;
			dqrv_pkg::ST_DECODE:   ram_we = (op_q == dqrv_pkg::OP_PUSH) && !is_full;
			dqrv_pkg::ST_SHIFT_WR: ram_we = 1'b1;
			default: begin
				s_tready = 1'b0;
				ram_we   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqrv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= dqrv_pkg::opcode_t'(s_tuser);
			key_q <= word_ext[WORD_WIDTH-1:0];
		end
	end

	// Advance count, oldest pointer, scan index and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			oldest_q <= '0;
			idx_q    <= '0;
			status_q <= dqrv_pkg::STAT_OK;
		end else begin
			case (state_q)
				dqrv_pkg::ST_DECODE: begin
					status_q <= dqrv_pkg::STAT_OK;
					idx_q    <= '0;
					case (op_q)
						dqrv_pkg::OP_PUSH: begin
							if (is_full) status_q <= dqrv_pkg::STAT_FULL;
							else count_q <= count_q + CW'(1);
						end
						dqrv_pkg::OP_POP_OLD: begin
							if (is_empty) begin
								status_q <= dqrv_pkg::STAT_EMPTY;
							end else begin
								oldest_q <= slot;
								count_q  <= count_q - CW'(1);
							end
						end
						dqrv_pkg::OP_POP_NEW: begin
							if (is_empty) status_q <= dqrv_pkg::STAT_EMPTY;
							else count_q <= count_q - CW'(1);
						end
						dqrv_pkg::OP_REMOVE: begin
							if (is_empty) status_q <= dqrv_pkg::STAT_EMPTY;
						end
						dqrv_pkg::OP_CLEAR: begin
							count_q  <= '0;
							oldest_q <= '0;
						end
						default: status_q <= dqrv_pkg::STAT_OK;
					endcase
				end
				dqrv_pkg::ST_SCAN_CMP: begin
					if (!hit) begin
						idx_q <= idx_inc;
						if (idx_inc == count_q) status_q <= dqrv_pkg::STAT_NOT_FOUND;
					end
				end
				dqrv_pkg::ST_SHIFT_RD: begin
					if (!(idx_inc < count_q)) count_q <= count_q - CW'(1);
				end
				dqrv_pkg::ST_SHIFT_WR: idx_q <= idx_inc;
				default: idx_q <= idx_q;
			endcase
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == dqrv_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dqrv_pkg::ST_DONE && out_free) begin
			out_status_q <= status_q;
			out_count_q  <= dqrv_pkg::COUNT_OUT_W'(count_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = dqrv_pkg::M_TDATA_W'({out_count_q, out_status_q});

	dqrv_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata ((state_q == dqrv_pkg::ST_SHIFT_WR) ? ram_rdata : key_q),
		.raddr (slot),
		.rdata (ram_rdata)
	);

	// Count never passes the store depth
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// Scan and shift only touch held entries
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dqrv_pkg::ST_SCAN_RD || state_q == dqrv_pkg::ST_SHIFT_WR)
		|-> idx_q < count_q)
		else $error("remove index outside held entries");

	// A new result is only loaded from the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == dqrv_pkg::ST_DONE))
		else $error("result raised outside done state");

	// No request is taken while a remove is still in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dqrv_pkg::ST_SHIFT_RD || state_q == dqrv_pkg::ST_SCAN_CMP) |-> !s_tready)
		else $error("request accepted mid operation");

endmodule

// ----- sv/dqrv_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.

module dqrv_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- test/deque_with_remove_by_value_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for deque_with_remove_by_value: a directed opening, then random
// bursts under several idle/stall mixes. Depends on dqrv_pkg.sv and the block's RTL.

module deque_with_remove_by_value_test;

	localparam int unsigned ENTRIES = dqrv_pkg::DEPTH_DEF;
	localparam int unsigned RANDOM_BURSTS = 11;
	localparam int unsigned BURST_LEN = 50;
	localparam int unsigned DRAIN_CYCLES = 2 * ENTRIES + 8;
	localparam logic [dqrv_pkg::OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [dqrv_pkg::OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [dqrv_pkg::OPCODE_W-1:0] OP_SPARE_LAST = 3'd7;

	typedef struct {
		dqrv_pkg::status_t status;
		logic [dqrv_pkg::COUNT_OUT_W-1:0] count;
	} reply_t;

	// Mirror of the store plus the queue of replies still owed by the block
	class deque_scoreboard;
		logic [dqrv_pkg::DATA_WORD_W-1:0] word_slots[ENTRIES];
		int unsigned oldest_slot;
		int unsigned held;
		reply_t awaited[$];
		int errors;

		function new();
			oldest_slot = 0;
			held = 0;
			errors = 0;
		endfunction

		function int unsigned slot_at(int unsigned k);
			return (oldest_slot + k) % ENTRIES;
		endfunction

		// Apply one accepted request to the mirror and queue its reply
		function void note_request(logic [dqrv_pkg::OPCODE_W-1:0] op,
			logic [dqrv_pkg::DATA_WORD_W-1:0] word);
			reply_t r;
			bit found;
			int unsigned hit;
			r.status = dqrv_pkg::STAT_OK;
			found = 0;
			hit = 0;
			case (dqrv_pkg::opcode_t'(op))
				dqrv_pkg::OP_PUSH: begin
					if (held >= ENTRIES) begin
						r.status = dqrv_pkg::STAT_FULL;
					end else begin
						word_slots[slot_at(held)] = word;
						held++;
					end
				end
				dqrv_pkg::OP_POP_OLD: begin
					if (held == 0) begin
						r.status = dqrv_pkg::STAT_EMPTY;
					end else begin
						oldest_slot = slot_at(1);
						held--;
					end
				end
				dqrv_pkg::OP_POP_NEW: begin
					if (held == 0) r.status = dqrv_pkg::STAT_EMPTY;
					else held--;
				end
				dqrv_pkg::OP_REMOVE: begin
					if (held == 0) begin
						r.status = dqrv_pkg::STAT_EMPTY;
					end else begin
						for (int unsigned i = 0; i < held && !found; i++) begin
							if (word_slots[slot_at(i)] === word) begin
								found = 1;
								hit = i;
							end
						end
						if (!found) begin
							r.status = dqrv_pkg::STAT_NOT_FOUND;
						end else begin
							// close the gap toward the oldest end
							for (int unsigned i = hit; i + 1 < held; i++)
								word_slots[slot_at(i)] = word_slots[slot_at(i + 1)];
							held--;
						end
					end
				end
				dqrv_pkg::OP_CLEAR: begin
					held = 0;
					oldest_slot = 0;
				end
				default: ;
			endcase
			r.count = held[dqrv_pkg::COUNT_OUT_W-1:0];
			awaited.insert(awaited.size(), r);
		endfunction

		// Compare one accepted result with the oldest owed reply
		function void check_result(logic [dqrv_pkg::M_TDATA_W-1:0] bus);
			reply_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, actual tdata %h", $time, bus);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (bus[dqrv_pkg::STATUS_W-1:0] !== want.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, want.status, bus[dqrv_pkg::STATUS_W-1:0]);
				errors++;
			end
			if (bus[dqrv_pkg::STATUS_W +: dqrv_pkg::COUNT_OUT_W] !== want.count) begin
				$display("%0t: entry_count mismatch, expected %0d actual %0d",
					$time, want.count, bus[dqrv_pkg::STATUS_W +: dqrv_pkg::COUNT_OUT_W]);
				errors++;
			end
		endfunction

		function logic [dqrv_pkg::DATA_WORD_W-1:0] any_held();
			return word_slots[slot_at($urandom_range(held - 1))];
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [dqrv_pkg::OPCODE_W-1:0] s_tuser = '0;
	logic [dqrv_pkg::DATA_WORD_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [dqrv_pkg::M_TDATA_W-1:0] m_tdata;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	deque_scoreboard board = new();

	deque_with_remove_by_value dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// Check accepted results and toggle backpressure
	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Hold off at random, then present one request until it is taken
	task automatic send_request(input logic [dqrv_pkg::OPCODE_W-1:0] op,
		input logic [dqrv_pkg::DATA_WORD_W-1:0] word);
		int unsigned gap;
		gap = 0;
		while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		board.note_request(op, word);
	endtask

	// Stop sending until every owed reply is back
	task automatic drain_replies();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.awaited.size() != 0);
	endtask

	function automatic logic [dqrv_pkg::DATA_WORD_W-1:0] pick_word();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45) return $urandom_range(7);
		if (r < 50) return '0;
		if (r < 55) return '1;
		return $urandom();
	endfunction

	// Draw one random request; growing bursts favor pushes to reach a full store
	task automatic send_random(input bit growing);
		int unsigned r;
		logic [dqrv_pkg::OPCODE_W-1:0] op;
		logic [dqrv_pkg::DATA_WORD_W-1:0] word;
		r = $urandom_range(99);
		word = pick_word();
		if (r < (growing ? 60 : 25)) op = dqrv_pkg::OP_PUSH;
		else if (r < (growing ? 70 : 48)) op = dqrv_pkg::OP_POP_OLD;
		else if (r < (growing ? 78 : 64)) op = dqrv_pkg::OP_POP_NEW;
		else if (r < 94) op = dqrv_pkg::OP_REMOVE;
		else if (r < 96) op = dqrv_pkg::OP_CLEAR;
		else op = dqrv_pkg::OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		// aim most removals at a word that is present
		if (op == dqrv_pkg::OP_REMOVE && board.held != 0 && $urandom_range(99) < 70)
			word = board.any_held();
		send_request(op, word);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty cases, extremes, matches at both ends, misses, spare codes
		send_request(dqrv_pkg::OP_POP_OLD, '0);
		send_request(dqrv_pkg::OP_POP_NEW, '1);
		send_request(dqrv_pkg::OP_REMOVE, '0);
		send_request(OP_SPARE_FIRST, '1);
		send_request(dqrv_pkg::OP_PUSH, '0);
		send_request(dqrv_pkg::OP_PUSH, '1);
		send_request(dqrv_pkg::OP_PUSH, 32'hA5A5_5A5A);
		send_request(dqrv_pkg::OP_PUSH, '0);
		send_request(dqrv_pkg::OP_PUSH, 32'h8000_0001);
		send_request(dqrv_pkg::OP_REMOVE, '0);
		send_request(dqrv_pkg::OP_REMOVE, 32'h1234_5678);
		send_request(dqrv_pkg::OP_REMOVE, 32'h8000_0001);
		send_request(OP_SPARE_MID, 32'h5A5A_A5A5);
		send_request(dqrv_pkg::OP_POP_NEW, '0);
		send_request(dqrv_pkg::OP_POP_OLD, '0);
		send_request(OP_SPARE_LAST, '0);
		send_request(dqrv_pkg::OP_CLEAR, '1);
		send_request(dqrv_pkg::OP_POP_OLD, '0);
		send_request(dqrv_pkg::OP_CLEAR, '0);
		drain_replies();

		// Random bursts, cycling through the idle and stall mixes
		for (int unsigned b = 0; b < RANDOM_BURSTS; b++) begin
			case (b % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 75; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 75; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			for (int unsigned n = 0; n < BURST_LEN; n++) send_random((b % 3) != 2);
			if (b % 4 == 3) drain_replies();
		end

		drain_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

endmodule

// ----- deque_with_remove_by_value.f -----
sv/dqrv_pkg.sv
sv/dqrv_ram.sv
sv/deque_with_remove_by_value.sv
test/deque_with_remove_by_value_test.sv
